[rtl/rpe_pkg.sv]
// Shared types and constants for the rotary position embedding block.
// Holds status codes, register indexes, FSM states, the command and status
// structs between controller and datapath, and the CORDIC arctangent table.
package rpe_pkg;

    localparam logic [2:0] CFG_HEAD_SIZE    = 3'd0;
    localparam logic [2:0] CFG_ROTARY_SIZE  = 3'd1;
    localparam logic [2:0] CFG_SPLIT_LAYOUT = 3'd2;
    localparam logic [2:0] CFG_FREQ_RATIO   = 3'd3;
    localparam logic [2:0] CFG_FREQ_SCALE   = 3'd4;
    localparam logic [2:0] CFG_AXIS_SPLIT   = 3'd5;

    // One turn as a 32-bit fraction per Q.24 radian, and pi/2 in Q30.
    localparam logic [29:0] TURN_K          = 30'd683565276;
    localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

    typedef enum logic [2:0] {
        ST_OK,
        ST_HEAD_ZERO,
        ST_LENGTH,
        ST_ROTARY,
        ST_FREQ,
        ST_SPLIT_SUM
    } t_status;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_ANG,
        S_PH0,
        S_PH1,
        S_ZINIT,
        S_CSTEP,
        S_QUAD,
        S_MUL0,
        S_MUL1,
        S_WR0,
        S_WR1,
        S_ORD,
        S_OLOAD,
        S_OWAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic ang;
        logic ph0;
        logic ph1;
        logic zinit;
        logic cstep;
        logic quad;
        logic mul0;
        logic mul1;
        logic wr0;
        logic wr1;
        logic ord;
        logic oload;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic chk_ok;
        logic cordic_last;
        logic pair_last;
        logic out_fire;
        logic out_last;
    } t_stat;

    // Truncated arctangent of 2^-k in Q30 radians.
    function automatic logic [31:0] atan_q30(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/rpe_in_if.sv]
// Input channel of the rotary position embedding block.
// One beat carries one element, the four positions and the last flag.
interface rpe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element_in;
    logic signed [31:0] pos_axis0;
    logic signed [31:0] pos_axis1;
    logic signed [31:0] pos_axis2;
    logic signed [31:0] pos_axis3;
    logic               last_element;

    modport source(output valid, element_in, pos_axis0, pos_axis1, pos_axis2, pos_axis3,
                   last_element, input ready);
    modport sink(input valid, element_in, pos_axis0, pos_axis1, pos_axis2, pos_axis3,
                 last_element, output ready);
endinterface

[rtl/rpe_out_if.sv]
// Output channel of the rotary position embedding block.
// One beat carries one result element, its last flag and the vector status.
interface rpe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element_out;
    logic               last_out;
    logic [2:0]         status;

    modport source(output valid, element_out, last_out, status, input ready);
    modport sink(input valid, element_out, last_out, status, output ready);
endinterface

[rtl/rpe_cfg_if.sv]
// Register write channel of the rotary position embedding block.
// One beat writes one register selected by index.
interface rpe_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/rotary_position_embedding.sv]
// Top level of the rotary position embedding block.
// Depends on rpe_pkg, the rpe_in_if, rpe_out_if and rpe_cfg_if interfaces,
// and the rpe_ctrl and rpe_dp modules.
//
//   channel  direction  beat contents
//   i_in     in         element_in, pos_axis0..3, last_element
//   o_out    out        element_out, last_out, status
//   i_cfg    in         index, data (register write)
//
// Loading accepts one element beat per cycle while i_in.valid is high. After
// the beat marked last, S_CHECK checks the settings; each pair is rotated
// through the angle, phase, CORDIC, quadrant, multiply and write states.
// Emitting runs S_ORD, S_OLOAD and S_OWAIT per element, waiting on o_out.
// Reset (i_rst_n low, synchronous) restores the register
// defaults and empties the vector; the memory itself needs no clearing.
// Input is taken only while loading; register writes are taken at any time.
module rotary_position_embedding import rpe_pkg::*; #(
    parameter int unsigned MAX_HEAD     = 64,
    parameter int unsigned NUM_AXES     = 4,
    parameter int unsigned CORDIC_STEPS = 24
) (
    input logic       i_clk,
    input logic       i_rst_n,
    rpe_in_if.sink    i_in,
    rpe_out_if.source o_out,
    rpe_cfg_if.sink   i_cfg
);

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences load, check, per-pair rotation and emit.
    rpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Input beats are accepted only in the load phase.
    assign i_in.ready  = cmd.load;
    // Register writes are always accepted.
    assign i_cfg.ready = 1'b1;

    rpe_dp #(
        .MAX_HEAD     (MAX_HEAD),
        .NUM_AXES     (NUM_AXES),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_valid     (i_in.valid),
        .i_element_in   (i_in.element_in),
        .i_pos_axis0    (i_in.pos_axis0),
        .i_pos_axis1    (i_in.pos_axis1),
        .i_pos_axis2    (i_in.pos_axis2),
        .i_pos_axis3    (i_in.pos_axis3),
        .i_last_element (i_in.last_element),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_element_out  (o_out.element_out),
        .o_last_out     (o_out.last_out),
        .o_status       (o_out.status)
    );

endmodule

[rtl/rpe_ctrl.sv]
// Sequencing state machine of the rotary position embedding block.
// Depends on rpe_pkg for the state enum and the command and status structs.
module rpe_ctrl import rpe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (i_stat.in_last) n_state = S_CHECK;
            S_CHECK: n_state = i_stat.chk_ok ? S_ANG : S_ORD;
            S_ANG:   n_state = S_PH0;
            S_PH0:   n_state = S_PH1;
            S_PH1:   n_state = S_ZINIT;
            S_ZINIT: n_state = S_CSTEP;
            S_CSTEP: if (i_stat.cordic_last) n_state = S_QUAD;
            S_QUAD:  n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_WR0;
            S_WR0:   n_state = S_WR1;
            S_WR1:   n_state = i_stat.pair_last ? S_ORD : S_ANG;
            S_ORD:   n_state = S_OLOAD;
            S_OLOAD: n_state = S_OWAIT;
            S_OWAIT: begin
                if (i_stat.out_fire) begin
                    n_state = i_stat.out_last ? S_LOAD : S_ORD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_LOAD:  o_cmd.load  = 1'b1;
            S_CHECK: o_cmd.check = 1'b1;
            S_ANG:   o_cmd.ang   = 1'b1;
            S_PH0:   o_cmd.ph0   = 1'b1;
            S_PH1:   o_cmd.ph1   = 1'b1;
            S_ZINIT: o_cmd.zinit = 1'b1;
            S_CSTEP: o_cmd.cstep = 1'b1;
            S_QUAD:  o_cmd.quad  = 1'b1;
            S_MUL0:  o_cmd.mul0  = 1'b1;
            S_MUL1:  o_cmd.mul1  = 1'b1;
            S_WR0:   o_cmd.wr0   = 1'b1;
            S_WR1:   o_cmd.wr1   = 1'b1;
            S_ORD:   o_cmd.ord   = 1'b1;
            S_OLOAD: o_cmd.oload = 1'b1;
            S_OWAIT: o_cmd = '0;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/rpe_dp.sv]
// Datapath of the rotary position embedding block: registers, vector memory,
// angle and frequency multipliers, iterative CORDIC and output register.
// Depends on rpe_pkg; driven by commands from rpe_ctrl.
module rpe_dp import rpe_pkg::*; #(
    parameter int unsigned MAX_HEAD     = 64,
    parameter int unsigned NUM_AXES     = 4,
    parameter int unsigned CORDIC_STEPS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_in_valid,
    input  logic signed [31:0] i_element_in,
    input  logic signed [31:0] i_pos_axis0,
    input  logic signed [31:0] i_pos_axis1,
    input  logic signed [31:0] i_pos_axis2,
    input  logic signed [31:0] i_pos_axis3,
    input  logic               i_last_element,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_element_out,
    output logic               o_last_out,
    output logic [2:0]         o_status
);

    localparam int unsigned AW = $clog2(MAX_HEAD);
    localparam int unsigned CW = $clog2(MAX_HEAD + 1);
    localparam int unsigned IW = $clog2(CORDIC_STEPS);

    // Configuration registers.
    logic [6:0]  r_head_size;
    logic [6:0]  r_rotary_size;
    logic        r_split_layout;
    logic [31:0] r_freq_ratio;
    logic [31:0] r_freq_scale;
    logic [63:0] r_axis_split;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_size    <= 7'd64;
            r_rotary_size  <= 7'd64;
            r_split_layout <= 1'b0;
            r_freq_ratio   <= 32'd0;
            r_freq_scale   <= 32'd16777216;
            r_axis_split   <= 64'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEAD_SIZE:    r_head_size    <= i_cfg_data[6:0];
                CFG_ROTARY_SIZE:  r_rotary_size  <= i_cfg_data[6:0];
                CFG_SPLIT_LAYOUT: r_split_layout <= i_cfg_data[0];
                CFG_FREQ_RATIO:   r_freq_ratio   <= i_cfg_data[31:0];
                CFG_FREQ_SCALE:   r_freq_scale   <= i_cfg_data[31:0];
                CFG_AXIS_SPLIT:   r_axis_split   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Vector collection state.
    logic [CW-1:0]      r_cnt;
    logic               r_ovf;
    logic signed [31:0] r_pos [4];
    logic               in_fire;

    // Pair loop and arithmetic registers.
    t_status            r_status;
    logic [5:0]         r_pairs;
    logic [5:0]         r_p;
    logic               r_split_on;
    logic [31:0]        r_freq;
    logic signed [55:0] r_ang;
    logic [57:0]        r_pp0;
    logic [31:0]        r_phase;
    logic [31:0]        r_xe;
    logic [31:0]        r_ye;
    logic signed [32:0] r_z;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic [IW-1:0]      r_i;
    logic [1:0]         r_quad;
    logic signed [33:0] r_c;
    logic signed [33:0] r_s;
    logic signed [65:0] r_m0;
    logic signed [65:0] r_m1;
    logic signed [65:0] r_m2;
    logic signed [65:0] r_m3;
    logic [31:0]        r_o0;
    logic [31:0]        r_o1;

    // Output side.
    logic [CW-1:0]      r_k;
    logic               r_ovalid;
    logic [31:0]        r_oelem;
    logic               r_olast;
    logic               out_fire;

    // Vector memory.
    logic [31:0]        mem [MAX_HEAD];
    logic [31:0]        r_rd;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [31:0]        mem_wd;
    logic [AW-1:0]      mem_ra;

    assign in_fire  = i_cmd.load & i_in_valid;
    assign out_fire = r_ovalid & i_out_ready;

    // Pair element indexes.
    logic [6:0] i0_full;
    logic [6:0] i1_full;
    assign i0_full = r_split_layout ? 7'(r_p) : {r_p, 1'b0};
    assign i1_full = r_split_layout ? (7'(r_p) + 7'(r_pairs)) : {r_p, 1'b1};

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt[AW-1:0];
        mem_wd = i_element_in;
        if (in_fire && (r_cnt < CW'(MAX_HEAD))) begin
            mem_we = 1'b1;
        end else if (i_cmd.wr0) begin
            mem_we = 1'b1;
            mem_wa = i0_full[AW-1:0];
            mem_wd = r_o0;
        end else if (i_cmd.wr1) begin
            mem_we = 1'b1;
            mem_wa = i1_full[AW-1:0];
            mem_wd = r_o1;
        end
    end

    always_comb begin
        if (i_cmd.ang) begin
            mem_ra = i0_full[AW-1:0];
        end else if (i_cmd.ph0) begin
            mem_ra = i1_full[AW-1:0];
        end else begin
            mem_ra = r_k[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    // Axis split: total of the used counts, and the axis of the current pair.
    logic [17:0] split_sum;
    logic [17:0] edge_acc;
    logic        axis_found;
    logic [1:0]  axis;

    always_comb begin
        split_sum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            split_sum = split_sum + 18'(r_axis_split[16*a +: 16]);
        end
    end

    always_comb begin
        edge_acc   = '0;
        axis_found = 1'b0;
        axis       = 2'd0;
        for (int a = 0; a < NUM_AXES; a++) begin
            edge_acc = edge_acc + 18'(r_axis_split[16*a +: 16]);
            if (!axis_found && (18'(r_p) < edge_acc)) begin
                axis       = 2'(a);
                axis_found = 1'b1;
            end
        end
        if (!r_split_on) begin
            axis = 2'd0;
        end
    end

    // Validity check of the settings and the vector length.
    t_status    chk_status;
    logic [6:0] n_len;
    assign n_len = 7'(r_cnt);

    always_comb begin
        priority if (r_head_size == 7'd0) begin
            chk_status = ST_HEAD_ZERO;
        end else if (r_ovf || (n_len != r_head_size)) begin
            chk_status = ST_LENGTH;
        end else if ((r_rotary_size == 7'd0) || (r_rotary_size > r_head_size)
                     || r_rotary_size[0]) begin
            chk_status = ST_ROTARY;
        end else if ((r_freq_ratio == 32'd0) || (r_freq_scale == 32'd0)) begin
            chk_status = ST_FREQ;
        end else if ((split_sum != 18'd0) && (split_sum != 18'(r_rotary_size[6:1]))) begin
            chk_status = ST_SPLIT_SUM;
        end else begin
            chk_status = ST_OK;
        end
    end

    // Arithmetic terms.
    logic signed [64:0] ang_full;
    logic [57:0]        pp1;
    logic [55:0]        phase_sum;
    logic [60:0]        zprod;
    logic [63:0]        fprod;
    logic [64:0]        fround;
    logic [33:0]        fshift;
    logic signed [32:0] at;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    assign ang_full  = r_pos[axis] * $signed({1'b0, r_freq});
    assign pp1       = r_ang[55:28] * TURN_K;
    assign phase_sum = {pp1[27:0], 28'd0} + r_pp0[55:0];
    assign zprod     = r_phase[29:0] * HALF_PI_Q30;
    assign fprod     = r_freq * r_freq_ratio;
    assign fround    = 65'(fprod) + 65'(64'd1 << 30);
    assign fshift    = fround[64:31];
    assign at        = $signed({1'b0, atan_q30(5'(r_i))});
    assign dx        = r_y >>> r_i;
    assign dy        = r_x >>> r_i;

    function automatic logic [31:0] sat_q46(input logic signed [66:0] v);
        logic signed [66:0] t;
        logic signed [36:0] r;
        t = v + 67'sd536870912;
        r = 37'(t >>> 30);
        if (r > 37'sd2147483647) begin
            return 32'h7FFFFFFF;
        end else if (r < -37'sd2147483648) begin
            return 32'h80000000;
        end
        return r[31:0];
    endfunction

    // Collection registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            for (int a = 0; a < 4; a++) begin
                r_pos[a] <= '0;
            end
        end else begin
            if (in_fire) begin
                if (r_cnt == '0) begin
                    r_pos[0] <= i_pos_axis0;
                    r_pos[1] <= i_pos_axis1;
                    r_pos[2] <= i_pos_axis2;
                    r_pos[3] <= i_pos_axis3;
                end
                if (r_cnt < CW'(MAX_HEAD)) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.oload) begin
                r_ovalid <= 1'b1;
            end else if (out_fire) begin
                r_ovalid <= 1'b0;
                if (r_olast) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end
            end
        end
    end

    // Pair loop datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_status   <= chk_status;
            r_pairs    <= r_rotary_size[6:1];
            r_freq     <= r_freq_scale;
            r_p        <= '0;
            r_split_on <= (split_sum != 18'd0);
            r_k        <= '0;
        end
        if (i_cmd.ang) begin
            r_ang <= ang_full[55:0];
        end
        if (i_cmd.ph0) begin
            r_pp0 <= r_ang[27:0] * TURN_K;
            r_xe  <= r_rd;
        end
        if (i_cmd.ph1) begin
            r_phase <= phase_sum[55:24];
            r_ye    <= r_rd;
        end
        if (i_cmd.zinit) begin
            r_z    <= $signed({2'b00, zprod[60:30]});
            r_x    <= 34'(CORDIC_GAIN_Q30);
            r_y    <= '0;
            r_i    <= '0;
            r_quad <= r_phase[31:30];
            r_freq <= (fshift[33:32] != 2'b00) ? 32'hFFFFFFFF : fshift[31:0];
        end
        if (i_cmd.cstep) begin
            if (!r_z[32]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.quad) begin
            unique case (r_quad)
                2'd0: begin r_c <= r_x;  r_s <= r_y;  end
                2'd1: begin r_c <= -r_y; r_s <= r_x;  end
                2'd2: begin r_c <= -r_x; r_s <= -r_y; end
                2'd3: begin r_c <= r_y;  r_s <= -r_x; end
            endcase
        end
        if (i_cmd.mul0) begin
            r_m0 <= $signed(r_xe) * r_c;
            r_m1 <= $signed(r_ye) * r_s;
        end
        if (i_cmd.mul1) begin
            r_m2 <= $signed(r_xe) * r_s;
            r_m3 <= $signed(r_ye) * r_c;
            r_o0 <= sat_q46(67'(r_m0) - 67'(r_m1));
        end
        if (i_cmd.wr0) begin
            r_o1 <= sat_q46(67'(r_m2) + 67'(r_m3));
        end
        if (i_cmd.wr1) begin
            r_p <= r_p + 1'b1;
        end
        if (i_cmd.oload) begin
            r_oelem <= r_rd;
            r_olast <= (CW'(r_k + 1'b1) == r_cnt);
            r_k     <= r_k + 1'b1;
        end
    end

    assign o_stat.in_last     = in_fire & i_last_element;
    assign o_stat.chk_ok      = (chk_status == ST_OK);
    assign o_stat.cordic_last = (r_i == IW'(CORDIC_STEPS - 1));
    assign o_stat.pair_last   = ((r_p + 6'd1) == r_pairs);
    assign o_stat.out_fire    = out_fire;
    assign o_stat.out_last    = r_olast;

    assign o_out_valid   = r_ovalid;
    assign o_element_out = r_oelem;
    assign o_last_out    = r_olast;
    assign o_status      = r_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_HEAD))
        else $error("element count beyond vector capacity");

    a_rotate_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cstep |-> (r_status == ST_OK))
        else $error("rotation running on a rejected vector");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && r_olast) |=> (r_cnt == '0) && !r_ovf)
        else $error("vector state not cleared after the last beat");

endmodule
